// File: rtl/lph_pkg.sv
`default_nettype none

package lph_pkg;

    // Operation kinds carried in the request.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Response status codes.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [63:0] key;
        logic [63:0] item_value;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [6:0]  entry_count;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr_run;
        logic       load;
        logic       div_step;
        logic       issue;
        logic       commit;
        logic       res_load;
        logic [2:0] res_code;
        logic       out_load;
    } lph_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic iss_all;
        logic chk_valid;
        logic chk_match;
        logic chk_empty;
        logic chk_last;
        logic hit;
        logic kind;
    } lph_sts_t;

endpackage

`default_nettype wire

// File: rtl/lph_dp.sv
`default_nettype none

module lph_dp
    import lph_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire lph_cmd_t  cmd,
    output lph_sts_t       sts,
    input  wire req_item_t req,
    output rsp_item_t      rsp
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int YW = SW + 16;
    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [YW-1:0] CAP_Y     = YW'(CAPACITY);
    localparam logic [16:0]   RECIP     = 17'((64'd1 << YW) / CAPACITY);

    typedef struct packed {
        logic        occ;
        logic [63:0] key;
        logic [63:0] value;
    } word_t;

    word_t mem [CAPACITY];

    // Control registers.
    logic          div_done_reg;
    logic [2:0]    div_cnt_reg;
    logic [CW-1:0] iss_cnt_reg;
    logic [SW-1:0] chk_cnt_reg;
    logic          rd_valid_reg;
    logic          found_reg;
    logic [CW-1:0] occ_cnt_reg;
    logic [SW-1:0] clr_addr_reg;

    // Payload registers.
    req_item_t     item_reg;
    logic [63:0]   div_key_reg;
    logic [16:0]   quo_reg;
    logic [SW-1:0] slot_reg;
    logic [63:0]   sum_reg;
    logic [SW-1:0] rd_slot_reg;
    word_t         rd_word_reg;
    logic [63:0]   found_val_reg;
    logic [2:0]    res_status_reg;
    logic [63:0]   res_value_reg;
    rsp_item_t     rsp_reg;

    logic [YW-1:0] div_y;
    logic [YW+16:0] div_prod;
    logic [YW-1:0] quo_y;
    logic [YW-1:0] div_rem;
    logic [YW-1:0] div_fix;
    logic [SW-1:0] slot_adv;
    logic          chk_match;
    logic          chk_empty;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    word_t         wr_word;

    // The key is reduced 16 bits at a time, most significant digit first. The first
    // step of a digit estimates the quotient with a reciprocal multiply; the estimate
    // is at most one short, so the second step needs a single corrective subtract.
    assign div_y    = {slot_reg, div_key_reg[63:48]};
    assign div_prod = (YW + 17)'(div_y) * (YW + 17)'(RECIP);
    assign quo_y    = YW'(quo_reg);
    assign div_rem  = div_y - quo_y * CAP_Y;
    assign div_fix  = (div_rem >= CAP_Y) ? div_rem - CAP_Y : div_rem;

    // When key + i wraps past 2^64 the probe restarts at slot zero.
    assign slot_adv = ((&sum_reg) || (slot_reg == LAST_SLOT)) ? '0 : slot_reg + 1'b1;

    assign chk_match = rd_valid_reg && rd_word_reg.occ && (rd_word_reg.key == item_reg.key);
    assign chk_empty = rd_valid_reg && !rd_word_reg.occ;

    assign sts.clr_last  = (clr_addr_reg == LAST_SLOT);
    assign sts.div_done  = div_done_reg;
    assign sts.iss_all   = (iss_cnt_reg == CAP_CNT);
    assign sts.chk_valid = rd_valid_reg;
    assign sts.chk_match = chk_match;
    assign sts.chk_empty = chk_empty;
    assign sts.chk_last  = (chk_cnt_reg == LAST_SLOT);
    assign sts.hit       = found_reg;
    assign sts.kind      = item_reg.kind;

    assign wr_en   = cmd.clr_run || cmd.commit;
    assign wr_addr = cmd.clr_run ? clr_addr_reg : rd_slot_reg;
    assign wr_word = cmd.clr_run ? word_t'('0)
                                 : word_t'({1'b1, item_reg.key, item_reg.item_value});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_word_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
            iss_cnt_reg  <= '0;
            chk_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            occ_cnt_reg  <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            if (cmd.clr_run)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                div_done_reg <= IS_POW2;
                div_cnt_reg  <= '0;
                iss_cnt_reg  <= '0;
                chk_cnt_reg  <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (&div_cnt_reg)
                    begin
                        div_done_reg <= 1'b1;
                    end
                end
                if (cmd.issue)
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    chk_cnt_reg <= chk_cnt_reg + 1'b1;
                end
                if (chk_match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit && chk_empty)
            begin
                occ_cnt_reg <= occ_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg    <= req;
            div_key_reg <= req.key;
            sum_reg     <= req.key;
            slot_reg    <= IS_POW2 ? req.key[SW-1:0] : '0;
        end
        else if (cmd.div_step)
        begin
            if (!div_cnt_reg[0])
            begin
                quo_reg <= div_prod[YW+16:YW];
            end
            else
            begin
                div_key_reg <= {div_key_reg[47:0], 16'd0};
                slot_reg    <= div_fix[SW-1:0];
            end
        end
        else if (cmd.issue)
        begin
            sum_reg  <= sum_reg + 64'd1;
            slot_reg <= slot_adv;
        end

        if (cmd.issue)
        begin
            rd_slot_reg <= slot_reg;
        end
        if (chk_match)
        begin
            found_val_reg <= rd_word_reg.value;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == ST_HIT)
            begin
                res_value_reg <= chk_match ? rd_word_reg.value : found_val_reg;
            end
            else
            begin
                res_value_reg <= '0;
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.status      <= res_status_reg;
            rsp_reg.read_value  <= res_value_reg;
            rsp_reg.entry_count <= 7'(occ_cnt_reg);
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/lph_ctrl.sv
`default_nettype none

module lph_ctrl
    import lph_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire           rsp_stall,
    output lph_cmd_t      cmd,
    input  wire lph_sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   usable;

    assign usable = sts.chk_valid && (sts.chk_match || sts.chk_empty);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    state_next = S_PROBE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_PROBE:
            begin
                if (sts.kind == KIND_INSERT)
                begin
                    if (usable)
                    begin
                        cmd.commit   = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_code = sts.chk_empty ? ST_INSERTED : ST_UPDATED;
                        state_next   = S_DONE;
                    end
                    else if (sts.chk_valid && sts.chk_last)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_FULL;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.issue = !sts.iss_all;
                    end
                end
                else
                begin
                    cmd.issue = !sts.iss_all;
                    if (sts.chk_valid && sts.chk_last)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = (sts.hit || sts.chk_match) ? ST_HIT : ST_MISS;
                        state_next   = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// File: rtl/linear_probe_hash_table.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_stall | req_item_t: kind, key, item_value
// rsp      | out       | rsp_valid / rsp_stall | rsp_item_t: status, read_value, entry_count
//
// After reset a clearing sweep marks every slot empty, one slot per cycle; requests are
// stalled until it ends.
// Each operation loads the request, reduces the key modulo CAPACITY (taking the low key
// bits when CAPACITY is a power of two, otherwise 16 key bits at a time), probes at one
// table read per cycle, and posts the response through a result and a response register.
// One operation is in flight at a time; the response register lets the next request be
// taken while a response still waits behind rsp_stall.
`default_nettype none

module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output rsp_item_t      rsp
);

    // The controller sequences clear, key reduction, probing and response;
    // the datapath holds the slot memory, counters and result registers.
    lph_cmd_t cmd;
    lph_sts_t sts;

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A transfer on req loads the item into the datapath in the same edge.
    lph_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/lph_checker.sv
`default_nettype none

module lph_checker
    import lph_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input wire            clk,
    input wire            rst_n,
    input wire            req_valid,
    input wire            req_stall,
    input wire req_item_t req,
    input wire            rsp_valid,
    input wire            rsp_stall,
    input wire rsp_item_t rsp
);

    localparam logic [6:0] FULL_COUNT = 7'(CAPACITY);

    // A stalled request holds its contents.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed");

    // A stalled response holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Only a lookup hit returns a nonzero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_HIT) |-> rsp.read_value == 64'd0)
        else $error("nonzero value on a response other than a hit");

    // A full table reports every slot occupied.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == FULL_COUNT)
        else $error("table full reported with free slots");

    // An accepted request is always followed by a stalled cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted twice in a row");

endmodule

bind linear_probe_hash_table lph_checker #(
    .CAPACITY (CAPACITY)
) u_lph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// File: verif/linear_probe_hash_table_tb.sv
`default_nettype none

module linear_probe_hash_table_tb;
    import lph_pkg::*;

    // The block under test uses its default capacity of 64 slots.
    localparam int CAPACITY = 64;

    // The slowest operation loads the request, reduces the key, probes every slot and posts
    // the response. Heavy stalling on either side can stretch each operation several times
    // over. Around 1550 operations therefore fit far below this.
    localparam int CYCLE_LIMIT = 1_000_000;

    // This is the quiet time after the last response. It is longer than one full operation,
    // so a stray extra response would still show up.
    localparam int DRAIN_CYCLES = 200;

    // These are the random operations in each of the four idling phases.
    localparam int PHASE_OPS = 385;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    linear_probe_hash_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // This is the shadow copy of the table that predicts every response. Keys and values
    // are only read in slots whose occupied flag is set, so the values they hold before
    // the first write do not matter.
    logic [63:0] slot_key   [CAPACITY];
    logic [63:0] slot_value [CAPACITY];
    logic        slot_used  [CAPACITY];
    int unsigned entries;

    req_item_t   pending_requests[$];
    rsp_item_t   predicted_responses[$];
    logic [63:0] known_keys[$];

    // The main process changes these knobs only at a falling edge. The clocked blocks read
    // them at the rising edge, so there is no race.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int error_count     = 0;
    int cycle_count     = 0;
    int status_seen [8] = '{default: 0};

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // This models one table operation and returns the response it must produce. Probe i
    // looks at slot (key + i) mod CAPACITY, and the sum wraps at 64 bits. An insert stops
    // at the first slot that is empty or that already holds its key. A lookup always scans
    // the whole probe sequence, and the match at the highest probe index wins.
    function automatic rsp_item_t predict_table_op(req_item_t op);
        rsp_item_t   res;
        logic [63:0] probe_key;
        int          slot;
        bit          placed;
        bit          found;
        res    = '0;
        placed = 1'b0;
        found  = 1'b0;
        if (op.kind == KIND_INSERT) begin
            res.status = ST_FULL;
            for (int i = 0; i < CAPACITY && !placed; i++) begin
                probe_key = op.key + 64'(i);
                slot      = int'(probe_key % 64'(CAPACITY));
                if (!slot_used[slot]) begin
                    slot_key[slot]   = op.key;
                    slot_value[slot] = op.item_value;
                    slot_used[slot]  = 1'b1;
                    entries++;
                    res.status = ST_INSERTED;
                    placed     = 1'b1;
                end else if (slot_key[slot] == op.key) begin
                    slot_value[slot] = op.item_value;
                    res.status       = ST_UPDATED;
                    placed           = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                probe_key = op.key + 64'(i);
                slot      = int'(probe_key % 64'(CAPACITY));
                if (slot_used[slot] && slot_key[slot] == op.key) begin
                    found          = 1'b1;
                    res.read_value = slot_value[slot];
                end
            end
            res.status = found ? ST_HIT : ST_MISS;
        end
        res.entry_count = 7'(entries);
        return res;
    endfunction

    function automatic req_item_t make_op(logic kind, logic [63:0] key, logic [63:0] val);
        req_item_t op;
        op.kind       = kind;
        op.key        = key;
        op.item_value = val;
        if (kind == KIND_INSERT)
            known_keys = {known_keys, key};
        return op;
    endfunction

    // This appends one operation to the tail of the pending queue.
    function automatic void add_pending(req_item_t op);
        pending_requests = {pending_requests, op};
    endfunction

    function automatic logic [63:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 64'd0;
        else if (pick < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // New keys come in three kinds. Fully random keys spread over the table. Keys whose low
    // bits fall in 0..7 pile up in the first few slots and build long probe chains. Keys
    // just below 2^64 make the probe sum wrap around.
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(2))
            0: ;
            1: k[5:0] = 6'($urandom_range(7));
            default: k = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(63));
        endcase
        return k;
    endfunction

    // Most operations reuse keys that were inserted before, so updates and hits make up a
    // good share. About one in ten inserts a new key. The table fills during the first
    // phases, and later new-key inserts test the table-full response.
    function automatic req_item_t random_op();
        int unsigned pick;
        logic [63:0] val;
        pick = $urandom_range(99);
        val  = random_value();
        if (pick < 35 && known_keys.size() > 0)
            return make_op(KIND_INSERT, known_keys[$urandom_range(known_keys.size() - 1)], val);
        else if (pick < 45)
            return make_op(KIND_INSERT, fresh_key(), val);
        else if (pick < 85 && known_keys.size() > 0)
            return make_op(KIND_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)], val);
        return make_op(KIND_LOOKUP, fresh_key(), val);
    endfunction

    // The request driver holds a presented transfer until it is accepted. When the channel
    // is free, it either idles or presents the next pending operation. The prediction is
    // made at the acceptance edge, so the response queue stays in transfer order.
    always @(posedge clk or negedge rst_n) begin : req_driver
        bit channel_free;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
        end else begin
            channel_free = !req_valid;
            if (req_valid && !req_stall) begin
                predicted_responses = {predicted_responses, predict_table_op(req)};
                channel_free = 1'b1;
            end
            if (channel_free) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req       <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    // The response monitor checks every accepted transfer against the oldest prediction.
    // It also draws a new random stall for the next cycle.
    always @(posedge clk or negedge rst_n) begin : rsp_monitor
        rsp_item_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (predicted_responses.size() == 0) begin
                    $display("%0t: response with none expected: status %0d value %h count %0d",
                             $time, rsp.status, rsp.read_value, rsp.entry_count);
                    error_count++;
                end else begin
                    want = predicted_responses.pop_front();
                    status_seen[want.status]++;
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(rsp.status));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, rsp.read_value);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(want.entry_count),
                                        64'(rsp.entry_count));
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time,
                     predicted_responses.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // This returns once every operation has been sent and every predicted response has come.
    task automatic wait_for_drain();
        @(negedge clk);
        while (pending_requests.size() > 0 || req_valid || predicted_responses.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_OPS)
            add_pending(random_op());
        wait_for_drain();
    endtask

    initial begin : stimulus
        // After reset the table is empty.
        for (int s = 0; s < CAPACITY; s++)
            slot_used[s] = 1'b0;
        entries = 0;

        // The directed operations run with no idling. The first is a lookup in the empty
        // table. Next come inserts at both ends of the key range. Key 64 collides with
        // key 0, and key 63 probes past slot 63, wraps to slot 0 and goes on along the
        // chain. Then come lookups that hit and miss, and updates that carry extreme values.
        // The last inserts use a key near 2^64 whose probe wraps from slot 63 to slot 0, and alternating bit patterns.
        add_pending(make_op(KIND_LOOKUP, 64'd0, '1));
        add_pending(make_op(KIND_INSERT, 64'd0, 64'd0));
        add_pending(make_op(KIND_INSERT, '1, '1));
        add_pending(make_op(KIND_INSERT, 64'd64, 64'h1234_5678_9ABC_DEF0));
        add_pending(make_op(KIND_INSERT, 64'd63, 64'd5));
        add_pending(make_op(KIND_LOOKUP, 64'd0, 64'd0));
        add_pending(make_op(KIND_LOOKUP, '1, 64'd0));
        add_pending(make_op(KIND_LOOKUP, 64'd64, '1));
        add_pending(make_op(KIND_LOOKUP, 64'd63, 64'd0));
        add_pending(make_op(KIND_LOOKUP, 64'd128, '1));
        add_pending(make_op(KIND_INSERT, 64'd0, '1));
        add_pending(make_op(KIND_LOOKUP, 64'd0, 64'd0));
        add_pending(make_op(KIND_INSERT, '1, 64'd0));
        add_pending(make_op(KIND_LOOKUP, '1, '1));
        add_pending(make_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFBF, 64'hAAAA_AAAA_AAAA_AAAA));
        add_pending(make_op(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFBF, 64'd0));
        add_pending(make_op(KIND_LOOKUP, 64'h8000_0000_0000_0000, '1));
        add_pending(make_op(KIND_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        add_pending(make_op(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        add_pending(make_op(KIND_LOOKUP, 64'h5555_5555_5555_5555, 64'd0));
        add_pending(make_op(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '1));

        // Reset is asserted at the start and then released. The block clears the table by itself and holds off
        // requests with stall until that is done.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_drain();

        // The random phases run with no idling, then a sender idle about half the time,
        // then a receiver that stalls about half the time, and last both sides idling lightly.
        run_random_phase(0, 0);
        run_random_phase(52, 0);
        run_random_phase(0, 52);
        run_random_phase(11, 11);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d new inserts, %0d updates, %0d table-full rejects,",
                 status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FULL]);
        $display("%0d hits and %0d misses, with no idling, sender gaps, receiver stalls and both.",
                 status_seen[ST_HIT], status_seen[ST_MISS]);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/lph_pkg.sv
rtl/lph_dp.sv
rtl/lph_ctrl.sv
rtl/linear_probe_hash_table.sv
rtl/lph_checker.sv
verif/linear_probe_hash_table_tb.sv
